@@ rtl/lru_kv_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// Depends on nothing; imported by every module of the block but the RAM.
package lru_kv_pkg;

  // Request opcodes (any other code acts as an exists probe)
  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_EXISTS = 2'd2;

  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
  } rsp_t;

  typedef enum logic [1:0] {
    RK_HOLD,
    RK_TOUCH,
    RK_INSERT
  } rank_op_e;

  typedef struct packed {
    rank_op_e op;
    logic     evict;
  } rank_cmd_t;

  typedef struct packed {
    logic hit;
    logic slot_ok;
  } probe_t;

endpackage

@@ rtl/lru_kv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the key and value stores.
module lru_kv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/lru_kv_probe.sv @@
// Shared compare unit: checks one stored entry against the request key
// and whether the entry can take an insert. Uses lru_kv_pkg.
module lru_kv_probe import lru_kv_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [31:0]   key_i,
  input  logic [31:0]   stored_key_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rank_i,
  input  logic [RW-1:0] victim_rank_i,
  input  logic          evict_i,
  output probe_t        probe_o
);

  always_comb begin
    probe_o.hit     = valid_i && (stored_key_i == key_i);
    // free slot, or the least recent entry when an eviction is due
    probe_o.slot_ok = !valid_i || (evict_i && (rank_i == victim_rank_i));
  end

endmodule

@@ rtl/lru_kv_ranks.sv @@
// Valid bits and recency ranks, one lane per entry, updated in one step.
// Uses lru_kv_pkg for the rank command.
module lru_kv_ranks import lru_kv_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int RW = IW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rank_cmd_t     cmd_i,
  input  logic [IW-1:0] slot_i,
  input  logic [RW-1:0] ref_rank_i,
  input  logic [IW-1:0] rd_idx_i,
  output logic          rd_valid_o,
  output logic [RW-1:0] rd_rank_o
);

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [RW-1:0]      rank_q [ENTRIES];
  logic [RW-1:0]      rank_d [ENTRIES];

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      valid_d[j] = valid_q[j];
      rank_d[j]  = rank_q[j];
      unique case (cmd_i.op)
        RK_HOLD: ;
        RK_TOUCH: begin
          if (valid_q[j] && (rank_q[j] < ref_rank_i)) begin
            rank_d[j] = rank_q[j] + RW'(1);
          end
        end
        RK_INSERT: begin
          if (valid_q[j]) begin
            if (cmd_i.evict && (rank_q[j] == ref_rank_i)) begin
              valid_d[j] = 1'b0;
            end else begin
              rank_d[j] = rank_q[j] + RW'(1);
            end
          end
        end
        default: ;
      endcase
      if ((slot_i == IW'(j)) && (cmd_i.op != RK_HOLD)) begin
        rank_d[j] = '0;
        if (cmd_i.op == RK_INSERT) begin
          valid_d[j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_q[j] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_q[j] <= rank_d[j];
      end
    end
  end

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: sequencer, key/value stores,
// rank lanes and the shared compare unit. Uses lru_kv_pkg and all rtl modules.
//
//   port group                  dir  handshake
//   start / busy / req_i        in   word taken when start high, busy low
//   done_o / rsp_o              out  one-cycle strobe, cannot be held off
//   cfg_we_i / cfg_wdata_i      in   capacity written when cfg_we_i high
//
// An item scans the key store one entry per cycle through the compare unit;
// the store's read data is registered, and the scan ends at the first hit
// or after the last entry. The result strobe comes in the cycle after the
// last busy cycle, when a new start may already be taken. Reset clears
// valid bits, ranks and occupancy at once and sets capacity to 16; no
// clearing pass follows. The receiver cannot stall.
module lru_key_value_cache import lru_kv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [OW-1:0]    cnt_q, cnt_d;
  logic             chk_q, chk_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             hit_q, hit_d;
  logic [IW-1:0]    hit_slot_q, hit_slot_d;
  logic [RW-1:0]    hit_rank_q, hit_rank_d;
  logic [31:0]      hit_val_q, hit_val_d;
  logic             ins_found_q, ins_found_d;
  logic [IW-1:0]    ins_slot_q, ins_slot_d;
  logic [OW-1:0]    occ_q, occ_d;
  logic [CAP_W-1:0] cap_q;
  req_t             req_q, req_d;
  rsp_t             rsp_q, rsp_d;
  logic             done_q, done_d;

  logic [CW-1:0]    cap_ext, eff_cap;
  logic             evict_need;
  logic [OW-1:0]    occ_m1;
  logic [RW-1:0]    victim_rank;

  logic [31:0]      key_rd, val_rd;
  logic             key_we, val_we;
  logic [IW-1:0]    val_waddr;
  logic [IW-1:0]    rd_addr;
  logic             lane_valid;
  logic [RW-1:0]    lane_rank;
  probe_t           probe;
  rank_cmd_t        rank_cmd;
  logic [IW-1:0]    rank_slot;
  logic [RW-1:0]    rank_ref;

  // Effective capacity: zero acts as one, saturate at the entry count
  always_comb begin
    cap_ext = CW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    evict_need  = CW'(occ_q) >= eff_cap;
    occ_m1      = occ_q - OW'(1);
    victim_rank = occ_m1[RW-1:0];
  end

  assign rd_addr = cnt_q[IW-1:0];

  lru_kv_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (ins_slot_q),
    .wdata_i (req_q.key),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  lru_kv_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (req_q.value),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  lru_kv_ranks #(.ENTRIES(ENTRIES)) u_ranks (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (rank_cmd),
    .slot_i     (rank_slot),
    .ref_rank_i (rank_ref),
    .rd_idx_i   (idx_q),
    .rd_valid_o (lane_valid),
    .rd_rank_o  (lane_rank)
  );

  lru_kv_probe #(.ENTRIES(ENTRIES)) u_probe (
    .key_i         (req_q.key),
    .stored_key_i  (key_rd),
    .valid_i       (lane_valid),
    .rank_i        (lane_rank),
    .victim_rank_i (victim_rank),
    .evict_i       (evict_need),
    .probe_o       (probe)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    chk_d       = 1'b0;
    idx_d       = idx_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_rank_d  = hit_rank_q;
    hit_val_d   = hit_val_q;
    ins_found_d = ins_found_q;
    ins_slot_d  = ins_slot_q;
    occ_d       = occ_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    val_waddr   = ins_slot_q;
    rank_cmd    = '{op: RK_HOLD, evict: 1'b0};
    rank_slot   = hit_slot_q;
    rank_ref    = hit_rank_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d       = req_i;
          cnt_d       = '0;
          hit_d       = 1'b0;
          ins_found_d = 1'b0;
          state_d     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // issue the next read while the previous entry is compared
        chk_d = cnt_q < OW'(ENTRIES);
        idx_d = cnt_q[IW-1:0];
        cnt_d = cnt_q + OW'(1);
        if (chk_q) begin
          if (probe.hit) begin
            hit_d      = 1'b1;
            hit_slot_d = idx_q;
            hit_rank_d = lane_rank;
            hit_val_d  = val_rd;
            chk_d      = 1'b0;
            state_d    = ST_FINISH;
          end else begin
            if (probe.slot_ok && !ins_found_q) begin
              ins_found_d = 1'b1;
              ins_slot_d  = idx_q;
            end
            if (idx_q == IW'(ENTRIES - 1)) begin
              chk_d   = 1'b0;
              state_d = ST_FINISH;
            end
          end
        end
      end
      ST_FINISH: begin
        rsp_d.found      = hit_q;
        rsp_d.read_value = '0;
        rsp_d.evicted    = 1'b0;
        unique case (req_q.operation)
          OP_GET: begin
            if (hit_q) begin
              rsp_d.read_value = hit_val_q;
              rank_cmd.op      = RK_TOUCH;
            end else begin
              rsp_d.read_value = MISS_VALUE;
            end
          end
          OP_PUT: begin
            val_we = 1'b1;
            if (hit_q) begin
              val_waddr   = hit_slot_q;
              rank_cmd.op = RK_TOUCH;
            end else begin
              key_we         = 1'b1;
              rank_cmd.op    = RK_INSERT;
              rank_cmd.evict = evict_need;
              rank_slot      = ins_slot_q;
              rank_ref       = victim_rank;
              rsp_d.evicted  = evict_need;
              if (!evict_need) begin
                occ_d = occ_q + OW'(1);
              end
            end
          end
          default: ;
        endcase
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      hit_q       <= 1'b0;
      ins_found_q <= 1'b0;
      occ_q       <= '0;
      cap_q       <= CAP_RESET;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      hit_q       <= hit_d;
      ins_found_q <= ins_found_d;
      occ_q       <= occ_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    hit_slot_q <= hit_slot_d;
    hit_rank_q <= hit_rank_d;
    hit_val_q  <= hit_val_d;
    ins_slot_q <= ins_slot_d;
    req_q      <= req_d;
    rsp_q      <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(ENTRIES))
    else $error("occupancy above entry count");

  a_start_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_SEARCH))
    else $error("accepted word did not start a search");

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_FINISH))
    else $error("result strobe without a finish step");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.evicted) |-> !rsp_o.found)
    else $error("eviction reported on a hit");

endmodule

@@ dv/lru_kv_monitor.sv @@
// Response monitor for the LRU key-value cache: keeps its own copy of the
// cache contents and recency order, predicts each response and compares it.
// Depends on lru_kv_pkg for the request and response types.
module lru_kv_monitor import lru_kv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  req_t             req_i,
  input  logic             done_i,
  input  rsp_t             rsp_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output int               pending_o,
  output int               fail_count_o,
  output int               hit_count_o,
  output int               evict_count_o
);

  logic [31:0]      key_mem [ENTRIES];
  logic [31:0]      val_mem [ENTRIES];
  logic             live    [ENTRIES];
  logic [3:0]       rank    [ENTRIES];
  logic [4:0]       fill;
  logic [CAP_W-1:0] capacity;
  rsp_t             awaited_rsp_q [$];

  // Move one entry to the front; entries ahead of it each age by one.
  task automatic promote(input int slot);
    logic [3:0] old_rank;
    old_rank = rank[slot];
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && rank[i] < old_rank) rank[i]++;
    rank[slot] = '0;
  endtask

  task automatic predict_access(input req_t req, output rsp_t rsp);
    int hit_slot;
    int victim;
    int free_slot;
    int limit;
    hit_slot  = -1;
    victim    = -1;
    free_slot = -1;
    limit = (capacity == '0) ? 1 : (capacity > ENTRIES) ? ENTRIES : int'(capacity);
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (live[i] && key_mem[i] == req.key) hit_slot = i;
    rsp = '0;
    rsp.found = (hit_slot >= 0);
    case (req.operation)
      OP_GET: begin
        if (hit_slot >= 0) begin
          rsp.read_value = val_mem[hit_slot];
          promote(hit_slot);
        end else begin
          rsp.read_value = MISS_VALUE;
        end
      end
      OP_PUT: begin
        if (hit_slot >= 0) begin
          val_mem[hit_slot] = req.value;
          promote(hit_slot);
        end else begin
          // Capacity may have been lowered under the fill level: drop just one.
          if (fill >= limit) begin
            for (int i = 0; i < ENTRIES; i++)
              if (live[i] && (victim < 0 || rank[i] > rank[victim])) victim = i;
            if (victim >= 0) begin
              live[victim] = 1'b0;
              rank[victim] = '0;
              if (fill != '0) fill--;
            end
            rsp.evicted = 1'b1;
          end
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!live[i]) free_slot = i;
          if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (live[i]) rank[i]++;
            key_mem[free_slot] = req.key;
            val_mem[free_slot] = req.value;
            live[free_slot]    = 1'b1;
            rank[free_slot]    = '0;
            fill++;
          end
        end
      end
      default: begin
        // exists probe; the spare code acts the same and touches nothing
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        live[i] = 1'b0;
        rank[i] = '0;
      end
      fill     = '0;
      capacity = CAP_RESET;
      awaited_rsp_q.delete();
      pending_o = 0;
    end else begin
      // Check the finishing word before taking a new one at the same edge.
      if (done_i) begin
        if (awaited_rsp_q.size() == 0) begin
          $display("%0t: unexpected response: expected none, got found %0b value %h evicted %0b",
                   $time, rsp_i.found, rsp_i.read_value, rsp_i.evicted);
          fail_count_o++;
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp_i.found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, got %0b",
                     $time, want.found, rsp_i.found);
            fail_count_o++;
          end
          if (rsp_i.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %h, got %h",
                     $time, want.read_value, rsp_i.read_value);
            fail_count_o++;
          end
          if (rsp_i.evicted !== want.evicted) begin
            $display("%0t: evicted mismatch: expected %0b, got %0b",
                     $time, want.evicted, rsp_i.evicted);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_access(req_i, want);
        awaited_rsp_q.push_back(want);
        if (want.found) hit_count_o++;
        if (want.evicted) evict_count_o++;
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
      pending_o = awaited_rsp_q.size();
    end
  end

endmodule

@@ dv/lru_key_value_cache_tb.sv @@
// Testbench top for lru_key_value_cache: drives requests and capacity writes
// and gives the verdict. Uses lru_kv_pkg, the cache and lru_kv_monitor.
module lru_key_value_cache_tb;
  import lru_kv_pkg::*;

  localparam int         ENTRIES     = 16;
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         PHASES      = 13;
  localparam int         PHASE_WORDS = 150;
  localparam int         POOL_MAX    = 24;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  req_t             req;
  logic             done;
  rsp_t             rsp;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int pending;
  int fail_count;
  int hit_count;
  int evict_count;
  int words_sent;
  int directed_words;
  int cap_writes;
  bit gaps_on;

  logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd8, 5'd2,
                                            5'd17, 5'd12, 5'd16, 5'd4, 5'd1, 5'd16};

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  lru_kv_monitor #(.ENTRIES(ENTRIES)) u_monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req),
    .done_i        (done),
    .rsp_i         (rsp),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .pending_o     (pending),
    .fail_count_o  (fail_count),
    .hit_count_o   (hit_count),
    .evict_count_o (evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not complete in time", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  // Hold start high until the word is taken; return at the next falling edge.
  task automatic send_word(input logic [1:0] op, input logic [31:0] k,
                           input logic [31:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    start <= 1'b1;
    req   <= '{operation: op, key: k, value: v};
    do @(posedge clk); while (busy);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cap_writes++;
  endtask

  initial begin
    logic [31:0] key_pool [POOL_MAX];
    logic [31:0] k;
    logic [31:0] v;
    logic [1:0]  op;
    int          pick;
    int          usable;
    int          pool_size;
    int          spin;

    rst_n     = 1'b0;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    gaps_on   = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty misses, extreme keys and values, updates, spare opcode.
    send_word(OP_GET,    32'h8000_0000, 32'h0000_0000);
    send_word(OP_EXISTS, 32'h7fff_ffff, 32'h0000_0000);
    send_word(OP_PUT,    32'h8000_0000, 32'h7fff_ffff);
    send_word(OP_PUT,    32'h7fff_ffff, 32'h8000_0000);
    send_word(OP_PUT,    32'h0000_0000, 32'hffff_ffff);
    send_word(OP_GET,    32'h8000_0000, 32'h0000_1234);
    send_word(OP_EXISTS, 32'h0000_0000, 32'hffff_ffff);
    send_word(OP_SPARE,  32'h7fff_ffff, 32'h0000_0000);
    send_word(OP_PUT,    32'h0000_0000, 32'h0000_0000);
    send_word(OP_GET,    32'hffff_ffff, 32'h0000_0000);
    // Capacity dropped under the fill level: each missing put drops one.
    set_capacity(5'd2);
    send_word(OP_PUT,    32'h0000_0001, 32'h0000_0001);
    send_word(OP_GET,    32'h7fff_ffff, 32'h0000_0000);
    send_word(OP_PUT,    32'h0000_0002, 32'h0000_0002);
    // Zero acts as one entry.
    set_capacity(5'd0);
    send_word(OP_PUT,    32'h0000_0003, 32'h0000_0003);
    send_word(OP_PUT,    32'h0000_0003, 32'h0000_0004);
    send_word(OP_GET,    32'h0000_0002, 32'h0000_0000);
    // Above the entry count saturates.
    set_capacity(5'd31);
    send_word(OP_PUT,    32'h0000_0010, 32'h0000_0a0a);
    send_word(OP_PUT,    32'h0000_0011, 32'h0000_0b0b);
    send_word(OP_PUT,    32'h0000_0012, 32'h0000_0c0c);
    send_word(OP_GET,    32'h0000_0010, 32'h0000_0000);
    directed_words = words_sent;

    phase_caps[8] = CAP_W'($urandom_range(1, ENTRIES));
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      gaps_on = (p < PHASES - 2);
      usable = (phase_caps[p] == '0) ? 1 :
               (phase_caps[p] > ENTRIES) ? ENTRIES : int'(phase_caps[p]);
      pool_size = usable + $urandom_range(1, 8);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
      if (p % 3 == 0) begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
      end
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (p == 4 && w == PHASE_WORDS / 2) wait_idle();
        pick = $urandom_range(0, 99);
        // Mostly keys from a small pool so hits and evictions are frequent.
        k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_size - 1)];
        case ($urandom_range(0, 15))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'hffff_ffff;
          default: v = $urandom;
        endcase
        if (pick < 40)      op = OP_PUT;
        else if (pick < 75) op = OP_GET;
        else if (pick < 95) op = OP_EXISTS;
        else                op = OP_SPARE;
        send_word(op, k, v);
      end
    end

    start <= 1'b0;
    spin = 0;
    while ((pending != 0 || busy) && spin < 500) begin
      @(negedge clk);
      spin++;
    end
    repeat (24) @(negedge clk);
    if (pending != 0) $display("%0t: %0d responses never arrived", $time, pending);
    $display("Sent %0d requests (%0d directed) over %0d capacity writes,",
             words_sent, directed_words, cap_writes);
    $display("checking %0d hits and %0d evictions against the predicted cache.",
             hit_count, evict_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lru_kv_pkg.sv
rtl/lru_kv_ram.sv
rtl/lru_kv_probe.sv
rtl/lru_kv_ranks.sv
rtl/lru_key_value_cache.sv
dv/lru_kv_monitor.sv
dv/lru_key_value_cache_tb.sv
